// ===== sv/assert_macros.svh =====
// assertion macros shared by the matcher rtl
// no dependencies; included by files that carry concurrent assertions
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising edge outside reset
`define MPLM_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// same-cycle implication built on the plain form
`define MPLM_ASSERT_IMPLY(label, clk, rst_n, pre, post, msg) \
  `MPLM_ASSERT(label, clk, rst_n, (pre) |-> (post), msg)

`endif

// ===== sv/mplm_pkg.sv =====
// shared types, constants and helpers of the multi-pattern line matcher
// no dependencies; imported by mplm_line_stat and multi_pattern_line_matcher
`default_nettype none

package mplm_pkg;

  // automaton size and counter width
  localparam int unsigned STATES      = 256;
  localparam int unsigned COUNT_WIDTH = 24;
  localparam int unsigned STATE_W     = $clog2(STATES);
  localparam int unsigned TBL_DEPTH   = STATES * 256;
  localparam int unsigned OUT_CNT_W   = 24;

  // request op codes
  typedef enum logic [2:0] {
    OP_LOAD_TRANS = 3'd0,
    OP_LOAD_TERM  = 3'd1,
    OP_TEXT       = 3'd2,
    OP_EOL        = 3'd3,
    OP_NEW_FILE   = 3'd4
  } op_e;

  // register indexes on the config port
  typedef enum logic [0:0] {
    REG_FOLD_CASE = 1'b0,
    REG_INVERT    = 1'b1
  } reg_e;

  // case fold constants
  localparam logic [7:0] LOWER_A  = 8'h61;
  localparam logic [7:0] LOWER_Z  = 8'h7A;
  localparam logic [7:0] CASE_OFS = 8'h20;
  localparam logic [7:0] UE_LOW   = 8'h81;
  localparam logic [7:0] UE_CAP   = 8'h9A;
  localparam logic [7:0] AE_LOW   = 8'h84;
  localparam logic [7:0] AE_CAP   = 8'h8E;
  localparam logic [7:0] OE_LOW   = 8'h94;
  localparam logic [7:0] OE_CAP   = 8'h99;

  // input request payload
  typedef struct packed {
    logic [2:0] op;
    logic [7:0] state_index;
    logic [7:0] byte_value;
    logic [7:0] next_state;
    logic       terminal_value;
  } in_req_t;

  // result payload
  typedef struct packed {
    logic                 line_selected;
    logic                 line_matched;
    logic [OUT_CNT_W-1:0] line_number;
    logic [OUT_CNT_W-1:0] match_count;
  } out_res_t;

  // event handed from the lookup stage to the line statistics stage
  typedef struct packed {
    logic valid;
    logic text;
    logic eol;
    logic new_file;
    logic nonroot;
  } stage_ev_t;

  // map a-z and three umlaut codes to their capitals
  function automatic logic [7:0] fold_byte(input logic [7:0] b);
    logic [7:0] r;
    r = b;
    if (b inside {[LOWER_A:LOWER_Z]}) begin
      r = b - CASE_OFS;
    end else if (b == UE_LOW) begin
      r = UE_CAP;
    end else if (b == AE_LOW) begin
      r = AE_CAP;
    end else if (b == OE_LOW) begin
      r = OE_CAP;
    end
    return r;
  endfunction

  // true when an 8-bit state number names an existing state
  function automatic logic state_ok(input logic [7:0] s);
    return (32'(s) < STATES);
  endfunction

  // state number as a table index, out-of-range targets go to the root
  function automatic logic [STATE_W-1:0] to_state(input logic [7:0] s);
    logic [STATE_W-1:0] r;
    r = '0;
    if (state_ok(s)) begin
      r = STATE_W'(s);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== sv/mplm_ram.sv =====
// generic single-port synchronous ram with a registered read
// no dependencies
`default_nettype none

module mplm_ram #(
  parameter int unsigned DEPTH = 256,
  parameter int unsigned WIDTH = 8
) (
  input  wire logic                     clk_i,
  input  wire logic                     en_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] addr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write or read one entry per enabled cycle
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem[addr_i] <= wdata_i;
      end else begin
        rdata_o <= mem[addr_i];
      end
    end
  end

endmodule

`default_nettype wire

// ===== sv/mplm_line_stat.sv =====
// line statistics stage: sticky match flag, saturating counters, result register
// depends on mplm_pkg
`default_nettype none

module mplm_line_stat (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire mplm_pkg::stage_ev_t ev_i,
  input  wire logic               term_i,
  input  wire logic               invert_i,
  input  wire logic               out_stall_i,
  output logic                    adv_o,
  output logic                    out_valid_o,
  output mplm_pkg::out_res_t      out_res_o
);

  import mplm_pkg::*;

  stage_ev_t              c_q;
  logic                   matched_q;
  logic [COUNT_WIDTH-1:0] lines_q;
  logic [COUNT_WIDTH-1:0] hits_q;
  logic [COUNT_WIDTH-1:0] lines_inc;
  logic [COUNT_WIDTH-1:0] hits_inc;
  logic                   ovalid_q;
  out_res_t               res_q;
  logic                   hit;

  function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] v);
    return (v == '1) ? v : v + 1'b1;
  endfunction

  // pipeline moves whenever the result register is free or being taken
  assign adv_o = !ovalid_q || !out_stall_i;

  // terminal flag of a non-root target marks the line
  always_comb begin
    hit       = c_q.valid && c_q.text && c_q.nonroot && term_i;
    lines_inc = sat_inc(lines_q);
    hits_inc  = matched_q ? sat_inc(hits_q) : hits_q;
  end

  // control and counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_q       <= '0;
      matched_q <= 1'b0;
      lines_q   <= '0;
      hits_q    <= '0;
      ovalid_q  <= 1'b0;
    end else if (adv_o) begin
      c_q      <= ev_i;
      ovalid_q <= c_q.valid && c_q.eol;
      if (hit) begin
        matched_q <= 1'b1;
      end
      if (c_q.valid && c_q.eol) begin
        lines_q   <= lines_inc;
        hits_q    <= hits_inc;
        matched_q <= 1'b0;
      end
      if (c_q.valid && c_q.new_file) begin
        lines_q   <= '0;
        hits_q    <= '0;
        matched_q <= 1'b0;
      end
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (adv_o && c_q.valid && c_q.eol) begin
      res_q.line_selected <= matched_q ^ invert_i;
      res_q.line_matched  <= matched_q;
      res_q.line_number   <= OUT_CNT_W'(lines_inc);
      res_q.match_count   <= OUT_CNT_W'(hits_inc);
    end
  end

  assign out_valid_o = ovalid_q;
  assign out_res_o   = res_q;

endmodule

`default_nettype wire

// ===== sv/multi_pattern_line_matcher.sv =====
// top level of the multi-pattern line matcher: config port, table lookup, flag lookup
// depends on mplm_pkg, mplm_ram, mplm_line_stat and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

// Walks text bytes through a loaded multi-pattern automaton, one request per clock
// cycle unless stalled. Load requests fill the next-state table (one entry per state
// and byte) and the terminal flags; text requests step the automaton, end-of-line
// requests present one result after the flag read and the statistics stage, and a
// new-file request clears the counters. The sustained rate is set by the next-state
// loop: the table read data feeds straight back into the address of the next byte's
// lookup, so one byte finishes its table read every cycle unless stalled. Both stores
// power up undefined and must be loaded before text is sent; there is no clearing
// pass. Input stall is raised only while a finished result waits at a stalled output.
module multi_pattern_line_matcher (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire mplm_pkg::in_req_t in_req_i,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output mplm_pkg::out_res_t     out_res_o,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [2:0]        paddr,
  input  wire logic [31:0]       pwdata,
  output logic [31:0]            prdata,
  output logic                   pready
);

  import mplm_pkg::*;

  logic               fold_q;
  logic               invert_q;
  logic               adv;
  logic               in_acc;
  op_e                in_op;
  logic [7:0]         byte_in;
  logic [7:0]         tbl_rdata;
  logic               tbl_we;
  logic [STATE_W+7:0] tbl_addr;
  logic               term_rdata;
  logic               term_we;
  logic [STATE_W-1:0] term_addr;
  logic [STATE_W-1:0] st_q;
  logic [STATE_W-1:0] st_d;
  logic [STATE_W-1:0] nxt;
  logic [STATE_W-1:0] cur;
  logic               b_valid_q;
  op_e                b_op_q;
  logic [7:0]         b_sidx_q;
  logic               b_term_q;
  logic               b_text;
  stage_ev_t          ev;
  reg_e               reg_sel;

  // config port
  assign pready  = 1'b1;
  assign reg_sel = reg_e'(paddr[2]);

  always_comb begin
    prdata = '0;
    case (reg_sel)
      REG_FOLD_CASE: prdata[0] = fold_q;
      REG_INVERT:    prdata[0] = invert_q;
      default:       prdata    = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fold_q   <= 1'b0;
      invert_q <= 1'b0;
    end else if (psel && penable && pwrite && pready) begin
      case (reg_sel)
        REG_FOLD_CASE: fold_q   <= pwdata[0];
        REG_INVERT:    invert_q <= pwdata[0];
        default:       fold_q   <= fold_q;
      endcase
    end
  end

  // request acceptance
  assign in_stall_o = !adv;
  assign in_acc     = in_valid_i && adv;
  assign in_op      = op_e'(in_req_i.op);

  // current state: forward the lookup just read, else the committed state
  always_comb begin
    nxt     = to_state(tbl_rdata);
    b_text  = b_valid_q && (b_op_q == OP_TEXT);
    cur     = b_text ? nxt : st_q;
    byte_in = fold_q ? fold_byte(in_req_i.byte_value) : in_req_i.byte_value;
  end

  // next-state table access, loads and lookups in request order
  always_comb begin
    tbl_we = in_acc && (in_op == OP_LOAD_TRANS) && state_ok(in_req_i.state_index);
    if (in_op == OP_LOAD_TRANS) begin
      tbl_addr = {STATE_W'(in_req_i.state_index), in_req_i.byte_value};
    end else begin
      tbl_addr = {cur, byte_in};
    end
  end

  mplm_ram #(
    .DEPTH (TBL_DEPTH),
    .WIDTH (8)
  ) u_tbl (
    .clk_i   (clk_i),
    .en_i    (adv),
    .we_i    (tbl_we),
    .addr_i  (tbl_addr),
    .wdata_i (in_req_i.next_state),
    .rdata_o (tbl_rdata)
  );

  // committed state, line ends and new files return to the root
  always_comb begin
    st_d = st_q;
    if (in_acc && ((in_op == OP_EOL) || (in_op == OP_NEW_FILE))) begin
      st_d = '0;
    end else if (b_text) begin
      st_d = nxt;
    end
  end

  // lookup stage control and payload
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q      <= '0;
      b_valid_q <= 1'b0;
    end else if (adv) begin
      st_q      <= st_d;
      b_valid_q <= in_acc;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      b_op_q   <= in_op;
      b_sidx_q <= in_req_i.state_index;
      b_term_q <= in_req_i.terminal_value;
    end
  end

  // terminal flag access, loads and lookups both in the second stage
  always_comb begin
    term_we   = b_valid_q && (b_op_q == OP_LOAD_TERM) && state_ok(b_sidx_q);
    term_addr = term_we ? STATE_W'(b_sidx_q) : nxt;
  end

  mplm_ram #(
    .DEPTH (STATES),
    .WIDTH (1)
  ) u_term (
    .clk_i   (clk_i),
    .en_i    (adv),
    .we_i    (term_we),
    .addr_i  (term_addr),
    .wdata_i (b_term_q),
    .rdata_o (term_rdata)
  );

  // event for the statistics stage
  always_comb begin
    ev.valid    = b_valid_q;
    ev.text     = b_text;
    ev.eol      = b_valid_q && (b_op_q == OP_EOL);
    ev.new_file = b_valid_q && (b_op_q == OP_NEW_FILE);
    ev.nonroot  = (nxt != '0);
  end

  mplm_line_stat u_stat (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ev_i        (ev),
    .term_i      (term_rdata),
    .invert_i    (invert_q),
    .out_stall_i (out_stall_i),
    .adv_o       (adv),
    .out_valid_o (out_valid_o),
    .out_res_o   (out_res_o)
  );

  // checks
  `MPLM_ASSERT_IMPLY(a_stall_only_on_held_result, clk_i, rst_ni, in_stall_o,
                     out_valid_o && out_stall_i, "input stalled without a held result")
  `MPLM_ASSERT_IMPLY(a_count_le_lines, clk_i, rst_ni, out_valid_o,
                     out_res_o.match_count <= out_res_o.line_number,
                     "match count above line number")
  `MPLM_ASSERT(a_matched_counted, clk_i, rst_ni,
               !(out_valid_o && out_res_o.line_matched && (out_res_o.match_count == '0)),
               "matched line with zero match count")

endmodule

`default_nettype wire

// ===== test/tb_multi_pattern_line_matcher.sv =====
// self-checking testbench for the multi-pattern line matcher: loads random automata,
// streams lines of text through them and checks every end-of-line result
// depends on mplm_pkg and multi_pattern_line_matcher
`timescale 1ns / 1ps

module tb_multi_pattern_line_matcher;
  import mplm_pkg::*;

  localparam int unsigned CYCLE_LIMIT   = 500_000;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned PHASES        = 5;
  localparam int unsigned PHASE_ITEMS   = 260;
  localparam int unsigned HOLD_AT_LINE  = 40;
  localparam int unsigned HOLD_CYCLES   = 300;
  localparam int unsigned MAX_REPORTS   = 10;

  // op codes the block must ignore
  localparam logic [2:0] OP_SPARE_LO = 3'd5;
  localparam logic [2:0] OP_SPARE_HI = 3'd7;

  // bytes every alphabet starts from: extremes, case edges and umlauts
  localparam logic [79:0] CORE_BYTES = {8'h00, 8'hFF, 8'h61, 8'h7A, 8'h81,
                                        8'h84, 8'h94, 8'h60, 8'h7B, 8'h41};

  logic        clk_i;
  logic        rst_ni = 1'b0;

  logic        drv_valid = 1'b0;
  in_req_t     drv_req = '0;
  logic        in_stall_o;
  logic        out_valid_o;
  logic        rx_stall = 1'b0;
  out_res_t    out_res_o;

  logic        apb_sel = 1'b0;
  logic        apb_enable = 1'b0;
  logic        apb_write = 1'b0;
  logic [2:0]  apb_addr = '0;
  logic [31:0] apb_wdata = '0;
  logic [31:0] prdata;
  logic        pready;

  multi_pattern_line_matcher dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (drv_valid),
    .in_stall_o  (in_stall_o),
    .in_req_i    (drv_req),
    .out_valid_o (out_valid_o),
    .out_stall_i (rx_stall),
    .out_res_o   (out_res_o),
    .psel        (apb_sel),
    .penable     (apb_enable),
    .pwrite      (apb_write),
    .paddr       (apb_addr),
    .pwdata      (apb_wdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // shadow automaton and line statistics
  logic [7:0]  next_tbl [0:65535];
  logic        pattern_end [0:255];
  logic [7:0]  walk_state = '0;
  logic        line_hit = 1'b0;
  logic [23:0] line_no = '0;
  logic [23:0] hit_cnt = '0;
  logic        fold_on = 1'b0;
  logic        invert_on = 1'b0;

  out_res_t    expected_lines [$];
  in_req_t     pending_reqs [$];
  int unsigned reqs_queued = 0;
  int unsigned reqs_accepted = 0;
  int unsigned lines_checked = 0;
  int unsigned mismatches = 0;
  int unsigned cycle_cnt = 0;

  // generator view of the current automaton
  logic [7:0]  live_states [$];
  logic [7:0]  alphabet [$];
  bit          in_live [256];
  bit          in_alpha [256];

  function automatic logic [7:0] upper_byte(input logic [7:0] b);
    if (b >= LOWER_A && b <= LOWER_Z) begin
      return b - CASE_OFS;
    end
    case (b)
      UE_LOW:  return UE_CAP;
      AE_LOW:  return AE_CAP;
      OE_LOW:  return OE_CAP;
      default: return b;
    endcase
  endfunction

  // advance the shadow automaton by one accepted request
  task automatic walk_request(input in_req_t r);
    logic [7:0] b;
    logic [7:0] nxt;
    out_res_t   res;
    case (r.op)
      OP_LOAD_TRANS: begin
        if (32'(r.state_index) < STATES) next_tbl[{r.state_index, r.byte_value}] = r.next_state;
      end
      OP_LOAD_TERM: begin
        if (32'(r.state_index) < STATES) pattern_end[r.state_index] = r.terminal_value;
      end
      OP_TEXT: begin
        b = fold_on ? upper_byte(r.byte_value) : r.byte_value;
        nxt = next_tbl[{walk_state, b}];
        if (32'(nxt) >= STATES) nxt = '0;
        walk_state = nxt;
        // the root never counts as a pattern end
        if (nxt != '0 && pattern_end[nxt]) line_hit = 1'b1;
      end
      OP_EOL: begin
        if (line_no != '1) line_no = line_no + 1'b1;
        if (line_hit && hit_cnt != '1) hit_cnt = hit_cnt + 1'b1;
        res.line_selected = line_hit ^ invert_on;
        res.line_matched  = line_hit;
        res.line_number   = line_no;
        res.match_count   = hit_cnt;
        expected_lines.push_back(res);
        walk_state = '0;
        line_hit   = 1'b0;
      end
      OP_NEW_FILE: begin
        line_no    = '0;
        hit_cnt    = '0;
        walk_state = '0;
        line_hit   = 1'b0;
      end
      default: ;
    endcase
  endtask

  // compare one delivered result with the oldest expected line
  task automatic check_line(input out_res_t got);
    out_res_t want;
    lines_checked++;
    if (expected_lines.size() == 0) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("unexpected result: sel=%0b hit=%0b line=%0d count=%0d",
                 got.line_selected, got.line_matched, got.line_number, got.match_count);
    end else begin
      want = expected_lines.pop_front();
      if (got.line_selected !== want.line_selected || got.line_matched !== want.line_matched ||
          got.line_number !== want.line_number || got.match_count !== want.match_count) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("line %0d mismatch: sel %0b/%0b hit %0b/%0b line %0d/%0d count %0d/%0d",
                   lines_checked, want.line_selected, got.line_selected, want.line_matched,
                   got.line_matched, want.line_number, got.line_number, want.match_count,
                   got.match_count);
      end
    end
  endtask

  // request driver: bursts of random length with random gaps
  int unsigned burst_left = 0;
  int unsigned gap_left = 0;

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      drv_valid <= 1'b0;
    end else begin
      if (drv_valid && !in_stall_o) begin
        walk_request(drv_req);
        reqs_accepted++;
      end
      if (!drv_valid || !in_stall_o) begin
        if (gap_left != 0) begin
          gap_left--;
          drv_valid <= 1'b0;
        end else if (pending_reqs.size() != 0) begin
          drv_req   <= pending_reqs.pop_front();
          drv_valid <= 1'b1;
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 32);
            gap_left   = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 10) : 0;
          end else begin
            burst_left--;
          end
        end else begin
          drv_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor and receiver stall pattern, with one long hold-off
  logic [31:0] stall_pat = '0;
  int unsigned pat_age = 0;
  int unsigned hold_left = 0;
  bit          hold_done = 1'b0;

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      rx_stall <= 1'b0;
    end else begin
      if (out_valid_o && !rx_stall) check_line(out_res_o);
      if (hold_left != 0) begin
        hold_left--;
        rx_stall <= 1'b1;
      end else if (lines_checked == HOLD_AT_LINE && !hold_done) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
        rx_stall <= 1'b1;
      end else begin
        if (pat_age == 0) begin
          pat_age = 64;
          case ($urandom_range(0, 3))
            0:       stall_pat = '0;
            1:       stall_pat = $urandom() & $urandom();
            2:       stall_pat = $urandom();
            default: stall_pat = $urandom() | $urandom();
          endcase
        end
        pat_age--;
        rx_stall <= stall_pat[0];
        stall_pat = {stall_pat[0], stall_pat[31:1]};
      end
    end
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("tb_multi_pattern_line_matcher failed");
      $finish;
    end
  end

  task automatic queue_req(input logic [2:0] op, input logic [7:0] sidx, input logic [7:0] bval,
                           input logic [7:0] nst, input logic term);
    in_req_t r;
    r.op             = op;
    r.state_index    = sidx;
    r.byte_value     = bval;
    r.next_state     = nst;
    r.terminal_value = term;
    pending_reqs.push_back(r);
    reqs_queued++;
  endtask

  // config write: setup cycle then access cycle
  task automatic write_reg(input reg_e idx, input logic val);
    @(posedge clk_i);
    apb_sel    <= 1'b1;
    apb_enable <= 1'b0;
    apb_write  <= 1'b1;
    apb_addr   <= {idx, 2'b00};
    apb_wdata  <= {31'd0, val};
    @(posedge clk_i);
    apb_enable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    apb_sel    <= 1'b0;
    apb_enable <= 1'b0;
    apb_write  <= 1'b0;
    if (idx == REG_FOLD_CASE) fold_on = val;
    else invert_on = val;
  endtask

  // wait until every request is taken and every line reported
  task automatic drain();
    do @(posedge clk_i); while (reqs_accepted != reqs_queued || expected_lines.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // keep the alphabet closed under case folding
  task automatic add_byte(input logic [7:0] b);
    logic [7:0] u;
    u = upper_byte(b);
    if (!in_alpha[b]) begin
      in_alpha[b] = 1'b1;
      alphabet.push_back(b);
    end
    if (!in_alpha[u]) begin
      in_alpha[u] = 1'b1;
      alphabet.push_back(u);
    end
  endtask

  function automatic logic [7:0] pick_target();
    if ($urandom_range(0, 4) < 2) return 8'h00;
    return live_states[$urandom_range(0, live_states.size() - 1)];
  endfunction

  function automatic logic [7:0] pick_byte();
    return alphabet[$urandom_range(0, alphabet.size() - 1)];
  endfunction

  // load a fresh automaton whose every reachable entry is written
  task automatic build_automaton(input int n_states, input int n_extra);
    logic [7:0] s;
    foreach (in_live[i]) in_live[i] = 1'b0;
    foreach (in_alpha[i]) in_alpha[i] = 1'b0;
    live_states.delete();
    alphabet.delete();
    live_states.push_back(8'h00);
    in_live[0] = 1'b1;
    while (live_states.size() < n_states) begin
      s = (live_states.size() == 1 && $urandom_range(0, 1)) ? 8'hFF : 8'($urandom_range(1, 255));
      if (!in_live[s]) begin
        in_live[s] = 1'b1;
        live_states.push_back(s);
      end
    end
    for (int k = 0; k < 10; k++) add_byte(CORE_BYTES[8*k +: 8]);
    repeat (n_extra) add_byte(8'($urandom_range(0, 255)));
    foreach (live_states[k])
      queue_req(OP_LOAD_TERM, live_states[k], 8'($urandom()), 8'($urandom()),
                $urandom_range(0, 2) == 0);
    queue_req(OP_LOAD_TERM, live_states[$urandom_range(1, live_states.size() - 1)],
              8'($urandom()), 8'($urandom()), 1'b1);
    foreach (live_states[k])
      foreach (alphabet[j])
        queue_req(OP_LOAD_TRANS, live_states[k], alphabet[j], pick_target(), 1'($urandom()));
  endtask

  // random lines over the loaded automaton, mixed with reloads and noise
  task automatic random_traffic(input int n);
    int         done_cnt;
    int         pick;
    logic [7:0] s;
    done_cnt = 0;
    while (done_cnt < n) begin
      pick = $urandom_range(0, 99);
      done_cnt++;
      if (pick < 58) begin
        queue_req(OP_TEXT, 8'($urandom()), pick_byte(), 8'($urandom()), 1'($urandom()));
      end else if (pick < 72) begin
        queue_req(OP_EOL, 8'($urandom()), 8'($urandom()), 8'($urandom()), 1'($urandom()));
      end else if (pick < 75) begin
        queue_req(OP_NEW_FILE, 8'($urandom()), 8'($urandom()), 8'($urandom()), 1'($urandom()));
      end else if (pick < 80) begin
        queue_req(3'($urandom_range(OP_SPARE_LO, OP_SPARE_HI)), 8'($urandom()), 8'($urandom()),
                  8'($urandom()), 1'($urandom()));
        done_cnt--;
      end else if (pick < 88) begin
        // rewire a live transition while text is flowing
        queue_req(OP_LOAD_TRANS, live_states[$urandom_range(0, live_states.size() - 1)],
                  pick_byte(), pick_target(), 1'($urandom()));
      end else if (pick < 92) begin
        queue_req(OP_LOAD_TERM, live_states[$urandom_range(0, live_states.size() - 1)],
                  8'($urandom()), 8'($urandom()), 1'($urandom()));
      end else begin
        // loads into states the walk cannot reach in this phase
        do s = 8'($urandom()); while (in_live[s]);
        queue_req($urandom_range(0, 1) ? OP_LOAD_TRANS : OP_LOAD_TERM, s, 8'($urandom()),
                  8'($urandom()), 1'($urandom()));
      end
    end
  endtask

  // stimulus sequence
  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    for (int ph = 0; ph < PHASES; ph++) begin
      if (ph < 4) begin
        write_reg(REG_FOLD_CASE, ph[0]);
        write_reg(REG_INVERT, ph[1]);
      end else begin
        write_reg(REG_FOLD_CASE, 1'($urandom()));
        write_reg(REG_INVERT, 1'($urandom()));
      end
      if (ph == 0) begin
        // small automaton: root flag set, pattern end at the top state, byte zero walks
        queue_req(OP_LOAD_TERM, 8'h00, 8'h00, 8'h00, 1'b1);
        queue_req(OP_LOAD_TERM, 8'hFF, 8'h00, 8'h00, 1'b1);
        queue_req(OP_LOAD_TERM, 8'h80, 8'h00, 8'h00, 1'b0);
        queue_req(OP_LOAD_TRANS, 8'h00, 8'h41, 8'hFF, 1'b0);
        queue_req(OP_LOAD_TRANS, 8'h00, 8'h00, 8'h80, 1'b0);
        queue_req(OP_LOAD_TRANS, 8'h80, 8'h00, 8'h00, 1'b0);
        queue_req(OP_LOAD_TRANS, 8'hFF, 8'h41, 8'h80, 1'b0);
        queue_req(OP_LOAD_TRANS, 8'h80, 8'h41, 8'h00, 1'b0);
        // empty line
        queue_req(OP_EOL, 8'h00, 8'h00, 8'h00, 1'b0);
        // back to the root through byte zero, no match
        queue_req(OP_TEXT, 8'h00, 8'h00, 8'h00, 1'b0);
        queue_req(OP_TEXT, 8'h00, 8'h00, 8'h00, 1'b0);
        queue_req(OP_EOL, 8'h00, 8'h00, 8'h00, 1'b0);
        // direct match
        queue_req(OP_TEXT, 8'h00, 8'h41, 8'h00, 1'b0);
        queue_req(OP_EOL, 8'hFF, 8'hFF, 8'hFF, 1'b1);
        // match stays set after walking away
        queue_req(OP_TEXT, 8'h00, 8'h41, 8'h00, 1'b0);
        queue_req(OP_TEXT, 8'h00, 8'h41, 8'h00, 1'b0);
        queue_req(OP_TEXT, 8'h00, 8'h00, 8'h00, 1'b0);
        queue_req(OP_EOL, 8'h00, 8'h00, 8'h00, 1'b0);
        // spare op codes and a new file
        queue_req(OP_SPARE_HI, 8'hFF, 8'hFF, 8'hFF, 1'b1);
        queue_req(OP_SPARE_LO, 8'h00, 8'h00, 8'h00, 1'b0);
        queue_req(OP_NEW_FILE, 8'h00, 8'h00, 8'h00, 1'b0);
        queue_req(OP_EOL, 8'h00, 8'h00, 8'h00, 1'b0);
      end
      build_automaton($urandom_range(3, 8), $urandom_range(4, 16));
      random_traffic(PHASE_ITEMS);
      drain();
    end
    if (mismatches == 0 && expected_lines.size() == 0) begin
      $display("tb_multi_pattern_line_matcher passed");
    end else begin
      $display("tb_multi_pattern_line_matcher failed");
    end
    $finish;
  end

endmodule
